// File: src/mps_pkg.sv
package mps_pkg;

    // Input item codes
    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Accepted packet version numbers
    localparam logic [2:0] VER_SPACE_PACKET = 3'd0;
    localparam logic [2:0] VER_ENCAP        = 3'd7;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_SIZE = 1'd0;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int OFF_W  = 6;

    // Smallest zone
    localparam logic [CFG_DATA_W-1:0] ZONE_MIN = 7'd2;

    // One result beat
    typedef struct packed {
        logic              frame_valid;
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_last;
        logic              header_present;
        logic [OFF_W-1:0]  first_header_offset;
        logic              frame_expedited;
        logic              accepted;
    } t_result;

endpackage

// File: src/mps_ram.sv
module mps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/map_packet_segmenter_unit.sv
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_func, i_data_byte, i_packet_start,
//          |              |              | i_packet_version, i_expedited, i_down_ready
// output   | o_out_valid  | i_out_stall  | o_frame_valid .. o_accepted
// config   | i_cfg_wr_en  | -            | i_cfg_idx, i_cfg_data
//
// A beat that yields a status result gives a single result beat. A beat that emits a
// zone has it read back one byte per cycle, while the output is not stalled, through
// the single registered read port of the zone RAM.
// Reset (synchronous, active low) clears fills, header-present flags, the per-entry
// valid bits that make unwritten zone bytes read as zero, and the output valid flag.
// Output stall holds the output register and pauses the zone read-back; input is
// stalled during an emission and while a held result waits.
module map_packet_segmenter_unit
    import mps_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_packet_start,
    input  logic [2:0]            i_packet_version,
    input  logic                  i_expedited,
    input  logic                  i_down_ready,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_frame_valid,
    output logic [BYTE_W-1:0]     o_frame_byte,
    output logic                  o_frame_last,
    output logic                  o_header_present,
    output logic [OFF_W-1:0]      o_first_header_offset,
    output logic                  o_frame_expedited,
    output logic                  o_accepted
);

    localparam int DEPTH = (BUFFER_BYTES < 64) ? BUFFER_BYTES : 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int RAM_D = 2 ** (AW + 1);
    localparam int RAW   = AW + 1;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state          r_state;
    logic [FW-1:0]   r_zone;
    logic [FW-1:0]   r_exp_fill, r_seq_fill;
    logic            r_exp_hp, r_seq_hp;
    logic [OFF_W-1:0] r_exp_off, r_seq_off;
    logic [RAM_D-1:0] r_vld;

    logic [FW-1:0]   n_exp_fill, n_seq_fill;
    logic            n_exp_hp, n_seq_hp;
    logic [OFF_W-1:0] n_exp_off, n_seq_off;

    // emission sequencer
    logic            r_buf_qe;
    logic            r_em_hp;
    logic [OFF_W-1:0] r_em_off;
    logic [FW-1:0]   r_rd_idx;
    logic            r_pend, r_pend_last, r_pend_vld;
    logic            r_wr_pending;
    logic [BYTE_W-1:0] r_wr_byte;

    // output stage
    logic            r_out_valid;
    t_result         r_out;

    logic            in_acc, out_take, load_byte, issue, finish;
    logic            dec_status, dec_emit, st_qe, st_acc;
    logic            em_qe, em_hp, defer_wr, wr_now;
    logic [OFF_W-1:0] em_off;
    logic [FW-1:0]   cur_fill, upd_fill;
    logic            cur_hp, upd_hp, ver_ok;
    logic [OFF_W-1:0] cur_off, upd_off;

    logic            ram_wr_en;
    logic [RAW-1:0]  ram_wr_addr, ram_rd_addr;
    logic [BYTE_W-1:0] ram_wr_data, ram_rd_data;

    // Handshakes
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state == S_EMIT) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_byte  = r_pend && (!r_out_valid || !i_out_stall);
    assign issue      = (r_state == S_EMIT) && (r_rd_idx < r_zone) && (!r_pend || load_byte);
    assign finish     = (r_state == S_EMIT) && load_byte && r_pend_last;

    // Decide what the accepted beat does
    always_comb begin
        n_exp_fill = r_exp_fill;
        n_seq_fill = r_seq_fill;
        n_exp_hp   = r_exp_hp;
        n_seq_hp   = r_seq_hp;
        n_exp_off  = r_exp_off;
        n_seq_off  = r_seq_off;
        dec_status = 1'b0;
        dec_emit   = 1'b0;
        st_qe      = 1'b0;
        st_acc     = 1'b0;
        em_qe      = 1'b0;
        em_hp      = 1'b0;
        em_off     = '0;
        defer_wr   = 1'b0;
        wr_now     = 1'b0;
        ver_ok     = (i_packet_version == VER_SPACE_PACKET) ||
                     (i_packet_version == VER_ENCAP);
        cur_fill   = i_expedited ? r_exp_fill : r_seq_fill;
        cur_hp     = i_expedited ? r_exp_hp : r_seq_hp;
        cur_off    = i_expedited ? r_exp_off : r_seq_off;
        upd_fill   = FW'(cur_fill + 1'b1);
        upd_hp     = cur_hp | i_packet_start;
        upd_off    = cur_hp ? cur_off : OFF_W'(cur_fill);
        if (in_acc) begin
            if (i_func == FUNC_FLUSH) begin
                if (r_exp_fill != '0) begin
                    st_qe = 1'b1;
                    if (!i_down_ready) begin
                        dec_status = 1'b1;
                    end else begin
                        dec_emit   = 1'b1;
                        em_qe      = 1'b1;
                        em_hp      = r_exp_hp;
                        em_off     = r_exp_off;
                        n_exp_fill = '0;
                        n_exp_hp   = 1'b0;
                    end
                end else if (r_seq_fill != '0 && i_down_ready) begin
                    dec_emit   = 1'b1;
                    em_hp      = r_seq_hp;
                    em_off     = r_seq_off;
                    n_seq_fill = '0;
                    n_seq_hp   = 1'b0;
                end else begin
                    dec_status = 1'b1;
                end
            end else if (!ver_ok) begin
                dec_status = 1'b1;
                st_qe      = i_expedited;
            end else if (cur_fill >= r_zone) begin
                st_qe = i_expedited;
                if (!i_down_ready) begin
                    dec_status = 1'b1;
                end else begin
                    // emit the full zone, then store the byte at its head
                    dec_emit = 1'b1;
                    defer_wr = 1'b1;
                    em_qe    = i_expedited;
                    em_hp    = cur_hp;
                    em_off   = cur_off;
                    if (i_expedited) begin
                        n_exp_fill = FW'(1);
                        n_exp_hp   = i_packet_start;
                        n_exp_off  = '0;
                    end else begin
                        n_seq_fill = FW'(1);
                        n_seq_hp   = i_packet_start;
                        n_seq_off  = '0;
                    end
                end
            end else begin
                // store the byte, then emit if the zone is now full and downstream is ready
                wr_now = 1'b1;
                st_qe  = i_expedited;
                st_acc = 1'b1;
                em_qe  = i_expedited;
                em_hp  = upd_hp;
                em_off = upd_off;
                if (upd_fill >= r_zone && i_down_ready) begin
                    dec_emit = 1'b1;
                    if (i_expedited) begin
                        n_exp_fill = '0;
                        n_exp_hp   = 1'b0;
                    end else begin
                        n_seq_fill = '0;
                        n_seq_hp   = 1'b0;
                    end
                end else begin
                    dec_status = 1'b1;
                    if (i_expedited) begin
                        n_exp_fill = upd_fill;
                        n_exp_hp   = upd_hp;
                        n_exp_off  = upd_off;
                    end else begin
                        n_seq_fill = upd_fill;
                        n_seq_hp   = upd_hp;
                        n_seq_off  = upd_off;
                    end
                end
            end
        end
    end

    // Zone RAM ports: expedited zone in the upper half
    assign ram_wr_en   = wr_now || (finish && r_wr_pending);
    assign ram_wr_addr = wr_now ? {i_expedited, AW'(cur_fill)} : {r_buf_qe, AW'(0)};
    assign ram_wr_data = wr_now ? i_data_byte : r_wr_byte;
    assign ram_rd_addr = {r_buf_qe, AW'(r_rd_idx)};

    mps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_D)
    ) u_zone_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Control state, sequencer and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_zone       <= FW'(DEPTH);
            r_exp_fill   <= '0;
            r_seq_fill   <= '0;
            r_exp_hp     <= 1'b0;
            r_seq_hp     <= 1'b0;
            r_vld        <= '0;
            r_rd_idx     <= '0;
            r_pend       <= 1'b0;
            r_pend_last  <= 1'b0;
            r_wr_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration: clamp the zone size between ZONE_MIN and what the buffer holds
            if (i_cfg_wr_en && i_cfg_idx == REG_PAYLOAD_SIZE) begin
                if (i_cfg_data < ZONE_MIN) begin
                    r_zone <= FW'(ZONE_MIN);
                end else if (i_cfg_data > CFG_DATA_W'(DEPTH)) begin
                    r_zone <= FW'(DEPTH);
                end else begin
                    r_zone <= FW'(i_cfg_data);
                end
            end

            r_exp_fill <= n_exp_fill;
            r_seq_fill <= n_seq_fill;
            r_exp_hp   <= n_exp_hp;
            r_seq_hp   <= n_seq_hp;

            if (ram_wr_en) begin
                r_vld[ram_wr_addr] <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (dec_emit) begin
                        r_state      <= S_EMIT;
                        r_rd_idx     <= '0;
                        r_pend       <= 1'b0;
                        r_wr_pending <= defer_wr;
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        r_rd_idx    <= FW'(r_rd_idx + 1'b1);
                        r_pend      <= 1'b1;
                        r_pend_last <= (r_rd_idx == FW'(r_zone - 1'b1));
                    end else if (load_byte) begin
                        r_pend <= 1'b0;
                    end
                    if (finish) begin
                        r_state      <= S_IDLE;
                        r_wr_pending <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if ((in_acc && dec_status) || load_byte) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_exp_off <= n_exp_off;
        r_seq_off <= n_seq_off;
        if (in_acc && dec_emit) begin
            r_buf_qe  <= em_qe;
            r_em_hp   <= em_hp;
            r_em_off  <= em_hp ? em_off : '0;
            r_wr_byte <= i_data_byte;
        end
        if (issue) begin
            r_pend_vld <= r_vld[ram_rd_addr];
        end
        if (in_acc && dec_status) begin
            r_out.frame_valid         <= 1'b0;
            r_out.frame_byte          <= '0;
            r_out.frame_last          <= 1'b1;
            r_out.header_present      <= 1'b0;
            r_out.first_header_offset <= '0;
            r_out.frame_expedited     <= st_qe;
            r_out.accepted            <= st_acc;
        end else if (load_byte) begin
            r_out.frame_valid         <= 1'b1;
            r_out.frame_byte          <= r_pend_vld ? ram_rd_data : '0;
            r_out.frame_last          <= r_pend_last;
            r_out.header_present      <= r_em_hp;
            r_out.first_header_offset <= r_em_off;
            r_out.frame_expedited     <= r_buf_qe;
            r_out.accepted            <= 1'b1;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_frame_valid         = r_out.frame_valid;
    assign o_frame_byte          = r_out.frame_byte;
    assign o_frame_last          = r_out.frame_last;
    assign o_header_present      = r_out.header_present;
    assign o_first_header_offset = r_out.first_header_offset;
    assign o_frame_expedited     = r_out.frame_expedited;
    assign o_accepted            = r_out.accepted;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_fill <= FW'(DEPTH)) && (r_seq_fill <= FW'(DEPTH)))
        else $error("zone fill beyond buffer size");

    a_byte_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_valid) |-> o_accepted)
        else $error("zone byte without accepted flag");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_valid) |-> o_frame_last)
        else $error("status result not marked last");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_pend && !issue))
        else $error("zone read outside an emission");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_state == S_IDLE) && !r_pend)
        else $error("emission did not close");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mps_pkg::*;

    localparam int BUFFER_BYTES = 64;
    localparam int ZONE_CAP     = 64;
    localparam int HDR_NONE     = 127;
    localparam int QUIET_LIMIT  = 4000;

    // Register index not named in the package
    localparam logic [CFG_IDX_W-1:0] REG_MAP_NUMBER = 1'd1;

    // One input beat as the sender sees it
    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data;
        logic              start;
        logic [2:0]        ver;
        logic              qe;
        logic              ready;
    } t_item;

    // Directed row: item plus, where obvious, the status beat it must give
    typedef struct packed {
        t_item item;
        logic  fixed;
        logic  want_qe;
        logic  want_acc;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_func;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  i_packet_start;
    logic [2:0]            i_packet_version;
    logic                  i_expedited;
    logic                  i_down_ready;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_frame_valid;
    logic [BYTE_W-1:0]     o_frame_byte;
    logic                  o_frame_last;
    logic                  o_header_present;
    logic [OFF_W-1:0]      o_first_header_offset;
    logic                  o_frame_expedited;
    logic                  o_accepted;

    // Side data travelling with the input beat
    logic    fixed_due;
    t_result fixed_beat;

    // Segmenter state kept by the testbench
    logic [BYTE_W-1:0] zone_mem [2][BUFFER_BYTES];
    int unsigned       zone_fill [2];
    int unsigned       hdr_at [2];
    int unsigned       cfg_size;
    int unsigned       cfg_map;

    t_result     step_beats [$];
    t_result     beats_due [$];
    bit          idle_on;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    int unsigned mismatch_count;
    int unsigned items_in;
    int unsigned beats_out;
    int unsigned zones_out;
    int unsigned reg_writes;

    localparam t_row PLAN_RESET [0:4] = '{
        '{'{FUNC_FLUSH, 8'h00, 1'b0, VER_SPACE_PACKET, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'h3C, 1'b1, 3'd3,             1'b1, 1'b1}, 1'b1, 1'b1, 1'b0},
        '{'{FUNC_BYTE,  8'hFF, 1'b1, 3'd6,             1'b0, 1'b1}, 1'b1, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'h81, 1'b1, VER_ENCAP,        1'b0, 1'b0}, 1'b1, 1'b0, 1'b1},
        // full 64-byte partial zone: one byte then never-written zeros
        '{'{FUNC_FLUSH, 8'h00, 1'b0, VER_SPACE_PACKET, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0}
    };

    localparam t_row PLAN_SMALL [0:17] = '{
        '{'{FUNC_BYTE,  8'hFF, 1'b1, VER_SPACE_PACKET, 1'b1, 1'b0}, 1'b1, 1'b1, 1'b1},
        // zone fills with downstream not ready: stored
        '{'{FUNC_BYTE,  8'h00, 1'b0, VER_ENCAP,        1'b1, 1'b0}, 1'b1, 1'b1, 1'b1},
        // zone full, not ready: dropped
        '{'{FUNC_BYTE,  8'h5A, 1'b0, VER_SPACE_PACKET, 1'b1, 1'b0}, 1'b1, 1'b1, 1'b0},
        '{'{FUNC_FLUSH, 8'h00, 1'b0, VER_SPACE_PACKET, 1'b0, 1'b0}, 1'b1, 1'b1, 1'b0},
        // full zone goes out first, then the byte opens a new one
        '{'{FUNC_BYTE,  8'hA5, 1'b1, VER_SPACE_PACKET, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'h12, 1'b0, VER_ENCAP,        1'b0, 1'b1}, 1'b1, 1'b0, 1'b1},
        // expedited zone wins the flush
        '{'{FUNC_FLUSH, 8'h00, 1'b0, VER_SPACE_PACKET, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0},
        '{'{FUNC_FLUSH, 8'h00, 1'b0, VER_SPACE_PACKET, 1'b1, 1'b0}, 1'b1, 1'b0, 1'b0},
        '{'{FUNC_FLUSH, 8'hFF, 1'b1, VER_ENCAP,        1'b1, 1'b1}, 1'b0, 1'b0, 1'b0},
        '{'{FUNC_FLUSH, 8'h00, 1'b0, VER_SPACE_PACKET, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'h34, 1'b0, VER_SPACE_PACKET, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b1},
        '{'{FUNC_BYTE,  8'h56, 1'b1, VER_SPACE_PACKET, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'h80, 1'b1, VER_ENCAP,        1'b1, 1'b1}, 1'b1, 1'b1, 1'b1},
        // second start in the same zone keeps the first offset
        '{'{FUNC_BYTE,  8'h7F, 1'b1, VER_ENCAP,        1'b1, 1'b1}, 1'b0, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'h01, 1'b0, 3'd1,             1'b0, 1'b1}, 1'b1, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'hFE, 1'b1, 3'd2,             1'b1, 1'b0}, 1'b1, 1'b1, 1'b0},
        '{'{FUNC_BYTE,  8'h00, 1'b0, 3'd4,             1'b0, 1'b1}, 1'b1, 1'b0, 1'b0},
        '{'{FUNC_BYTE,  8'hFF, 1'b1, 3'd5,             1'b1, 1'b1}, 1'b1, 1'b1, 1'b0}
    };

    map_packet_segmenter_unit #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_func                (i_func),
        .i_data_byte           (i_data_byte),
        .i_packet_start        (i_packet_start),
        .i_packet_version      (i_packet_version),
        .i_expedited           (i_expedited),
        .i_down_ready          (i_down_ready),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_frame_valid         (o_frame_valid),
        .o_frame_byte          (o_frame_byte),
        .o_frame_last          (o_frame_last),
        .o_header_present      (o_header_present),
        .o_first_header_offset (o_first_header_offset),
        .o_frame_expedited     (o_frame_expedited),
        .o_accepted            (o_accepted)
    );

    // Free-running clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Zone size after saturation to the legal range
    function automatic int unsigned zone_len();
        int unsigned s;
        s = cfg_size;
        if (s < ZONE_MIN) begin
            s = ZONE_MIN;
        end
        if (s > ZONE_CAP) begin
            s = ZONE_CAP;
        end
        return s;
    endfunction

    task automatic push_status(input logic qe, input logic acc);
        t_result b;
        b                 = '0;
        b.frame_last      = 1'b1;
        b.frame_expedited = qe;
        b.accepted        = acc;
        step_beats.push_back(b);
    endtask

    // Stream a whole zone out, then empty it
    task automatic emit_zone(input logic qe);
        int unsigned n;
        t_result     b;
        n                   = zone_len();
        b                   = '0;
        b.frame_valid       = 1'b1;
        b.header_present    = (hdr_at[qe] != HDR_NONE);
        b.first_header_offset = b.header_present ? OFF_W'(hdr_at[qe]) : '0;
        b.frame_expedited   = qe;
        b.accepted          = 1'b1;
        for (int unsigned i = 0; i < n; i++) begin
            b.frame_byte = zone_mem[qe][i];
            b.frame_last = (i + 1 == n);
            step_beats.push_back(b);
        end
        zone_fill[qe] = 0;
        hdr_at[qe]    = HDR_NONE;
    endtask

    // Work out the result beats of one input beat and advance the zone state
    task automatic segment_item(input t_item it);
        int unsigned n;
        int unsigned q;
        step_beats.delete();
        n = zone_len();
        q = it.qe;
        if (it.func == FUNC_FLUSH) begin
            if (zone_fill[1] > 0) begin
                if (it.ready) emit_zone(1'b1);
                else push_status(1'b1, 1'b0);
            end else if (zone_fill[0] > 0) begin
                if (it.ready) emit_zone(1'b0);
                else push_status(1'b0, 1'b0);
            end else begin
                push_status(1'b0, 1'b0);
            end
            return;
        end
        if (it.ver != VER_SPACE_PACKET && it.ver != VER_ENCAP) begin
            push_status(it.qe, 1'b0);
            return;
        end
        if (zone_fill[q] >= n) begin
            if (!it.ready) begin
                push_status(it.qe, 1'b0);
                return;
            end
            emit_zone(it.qe);
        end
        if (it.start && hdr_at[q] == HDR_NONE) begin
            hdr_at[q] = zone_fill[q];
        end
        if (zone_fill[q] < BUFFER_BYTES) begin
            zone_mem[q][zone_fill[q]] = it.data;
            zone_fill[q]++;
        end
        if (step_beats.size() == 0 && zone_fill[q] >= n && it.ready) begin
            emit_zone(it.qe);
        end
        if (step_beats.size() == 0) begin
            push_status(it.qe, 1'b1);
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] result beat %0d: %s", $realtime, beats_out, msg);
        end
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Present one beat, with an occasional idle burst ahead of it, and hold
    // it until taken
    task automatic drive_item(input t_item it, input logic fixed, input t_result want);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= it.func;
        i_data_byte      <= it.data;
        i_packet_start   <= it.start;
        i_packet_version <= it.ver;
        i_expedited      <= it.qe;
        i_down_ready     <= it.ready;
        fixed_due        <= fixed;
        fixed_beat       <= want;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    task automatic drive_row(input t_row row);
        t_result want;
        want                 = '0;
        want.frame_last      = 1'b1;
        want.frame_expedited = row.want_qe;
        want.accepted        = row.want_acc;
        drive_item(row.item, row.fixed, want);
    endtask

    // Wait until every due beat has arrived, then a little longer
    task automatic wait_drained(input int unsigned tail);
        @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] size, input logic [3:0] map_id);
        i_in_valid <= 1'b0;
        wait_drained(4);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= REG_PAYLOAD_SIZE;
        i_cfg_data  <= size;
        @(posedge i_clk);
        cfg_size    = size;
        i_cfg_idx   <= REG_MAP_NUMBER;
        i_cfg_data  <= CFG_DATA_W'(map_id);
        @(posedge i_clk);
        cfg_map     = map_id;
        i_cfg_wr_en <= 1'b0;
        reg_writes += 2;
    endtask

    // Mostly well-formed packets with random content, some flushes and noise
    task automatic run_random(input int unsigned quota);
        int unsigned done_items;
        int unsigned len;
        int unsigned pick;
        logic [2:0]  pkt_ver;
        t_item       it;
        done_items = 0;
        while (done_items < quota) begin
            pick     = $urandom_range(0, 99);
            it.data  = BYTE_W'($urandom_range(0, 255));
            it.ready = ($urandom_range(0, 3) != 0);
            it.qe    = 1'($urandom_range(0, 1));
            it.start = 1'($urandom_range(0, 1));
            it.ver   = 3'($urandom_range(0, 7));
            if (pick < 8) begin
                it.func = FUNC_FLUSH;
                drive_item(it, 1'b0, '0);
                done_items++;
            end else if (pick < 14) begin
                it.func = FUNC_BYTE;
                it.ver  = 3'($urandom_range(1, 6));
                drive_item(it, 1'b0, '0);
                done_items++;
            end else begin
                it.func = FUNC_BYTE;
                pkt_ver = $urandom_range(0, 1) ? VER_ENCAP : VER_SPACE_PACKET;
                len     = $urandom_range(1, zone_len() + zone_len() / 2);
                for (int unsigned k = 0; k < len && done_items < quota; k++) begin
                    it.data  = BYTE_W'($urandom_range(0, 255));
                    it.ready = ($urandom_range(0, 3) != 0);
                    it.start = (k == 0);
                    // stray or missing start flag
                    if ($urandom_range(0, 19) == 0) begin
                        it.start = ~it.start;
                    end
                    // corrupt version in the middle of a packet
                    it.ver = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(1, 6)) : pkt_ver;
                    drive_item(it, 1'b0, '0);
                    done_items++;
                end
            end
        end
    endtask

    // Predict on every accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            segment_item('{i_func, i_data_byte, i_packet_start, i_packet_version,
                           i_expedited, i_down_ready});
            items_in++;
            if (fixed_due) begin
                beats_due.push_back(fixed_beat);
            end else begin
                foreach (step_beats[k]) beats_due.push_back(step_beats[k]);
            end
        end
    end

    // Compare every accepted result beat with the oldest one due
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (beats_due.size() == 0) begin
                flag_mismatch("result beat with nothing due");
            end else begin
                want = beats_due.pop_front();
                check_field("frame_valid", o_frame_valid, want.frame_valid);
                check_field("frame_byte", o_frame_byte, want.frame_byte);
                check_field("frame_last", o_frame_last, want.frame_last);
                check_field("header_present", o_header_present, want.header_present);
                check_field("first_header_offset", o_first_header_offset,
                            want.first_header_offset);
                check_field("frame_expedited", o_frame_expedited, want.frame_expedited);
                check_field("accepted", o_accepted, want.accepted);
            end
            if (o_frame_valid && o_frame_last) begin
                zones_out++;
            end
            beats_out++;
        end
    end

    // Output stall in random bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
        end else if (stall_left == 0 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        i_out_stall <= (stall_left > 0);
        if (stall_left > 0) begin
            stall_left--;
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d beats still due",
                     quiet_cycles, beats_due.size());
            $display("map_packet_segmenter_unit regression: fail");
            $finish;
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          <= 1'b0;
        i_cfg_wr_en      <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_func           <= FUNC_BYTE;
        i_data_byte      <= '0;
        i_packet_start   <= 1'b0;
        i_packet_version <= VER_SPACE_PACKET;
        i_expedited      <= 1'b0;
        i_down_ready     <= 1'b0;
        i_out_stall      <= 1'b0;
        fixed_due        <= 1'b0;
        fixed_beat       <= '0;
        idle_on          = 1'b1;
        stall_left       = 0;
        quiet_cycles     = 0;
        mismatch_count   = 0;
        items_in         = 0;
        beats_out        = 0;
        zones_out        = 0;
        reg_writes       = 0;
        cfg_size         = 64;
        cfg_map          = 0;
        for (int q = 0; q < 2; q++) begin
            zone_fill[q] = 0;
            hdr_at[q]    = HDR_NONE;
            for (int i = 0; i < BUFFER_BYTES; i++) zone_mem[q][i] = '0;
        end

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, then the smallest zone
        foreach (PLAN_RESET[i]) drive_row(PLAN_RESET[i]);
        set_config(7'd0, 4'd15);
        foreach (PLAN_SMALL[i]) drive_row(PLAN_SMALL[i]);

        // Random phases over several settings
        set_config(7'd5, 4'd3);
        run_random(20);
        set_config(7'd127, 4'd15);
        run_random(15);
        set_config(7'd1, 4'd0);
        run_random(15);
        set_config(CFG_DATA_W'($urandom_range(3, 12)), 4'($urandom_range(0, 15)));
        run_random(20);
        set_config(7'd64, 4'd9);
        run_random(4);
        set_config(7'd4, 4'd6);
        idle_on = 1'b0;
        run_random(13);
        i_in_valid <= 1'b0;

        // Drain and let a full zone read-back time pass
        wait_drained(ZONE_CAP + 8);
        if (beats_due.size() != 0) begin
            flag_mismatch($sformatf("%0d result beats never arrived", beats_due.size()));
        end

        $display("Run covered %0d input beats, %0d result beats, %0d zones emitted",
                 items_in, beats_out, zones_out);
        $display("%0d register writes, zone sizes from 2 to 64, %0d mismatches",
                 reg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("map_packet_segmenter_unit regression: pass");
        end else begin
            $display("map_packet_segmenter_unit regression: fail");
        end
        $finish;
    end

endmodule
